@@ hw/rtl/millisecond_tick_timer_slots_core_assert.svh @@
// Assertion macros for the checker in mtts_checker.sv.
`ifndef MILLISECOND_TICK_TIMER_SLOTS_CORE_ASSERT_SVH
`define MILLISECOND_TICK_TIMER_SLOTS_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define MTTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtts assertion failed");

// next-cycle implication
`define MTTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtts assertion failed");

`endif

@@ hw/rtl/mtts_pkg.sv @@
package mtts_pkg;

    localparam int SLOT_COUNT_DEF = 3;

    localparam int CMD_W      = 2;
    localparam int ID_W       = 8;
    localparam int TIME_W     = 32;
    localparam int EV_W       = 3;
    localparam int S_TDATA_W  = 40;   // timer_id, delay_ms
    localparam int M_TDATA_W  = 48;   // fired_id, led_on, time_ms, zero pad
    localparam int REG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int DIVIDEND_W    = TIME_W;
    localparam int DIVISOR_W     = 16;
    localparam int DIV_STEP_BITS = 4;

    localparam int LED_MOD_W    = 4;
    localparam int LED_MOD      = 10;
    localparam int LED_OFF_FROM = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [EV_W-1:0] {
        EV_QUIET = 3'd0,
        EV_MIX   = 3'd1,
        EV_RF    = 3'd2,
        EV_FIRED = 3'd3,
        EV_DONE  = 3'd4,
        EV_FULL  = 3'd5
    } ev_t;

    localparam logic [REG_IDX_W-1:0] REG_RF_ENABLE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_RF_PERIOD = 1'b1;

    typedef struct packed {
        logic                 done;
        logic [DIVISOR_W-1:0] rem;
    } div_stat_t;

endpackage

@@ hw/rtl/millisecond_tick_timer_slots_core.sv @@
// Set / clear: the slots are scanned one slot per cycle, then the result beat is flushed.
// Tick: scans every slot, after the remainder unit (4 bits a cycle) when RF events are on.
// Unused command and set / clear with id zero: no scan. An output stall holds the item back.
// Results leave through a one-beat output register; the last beat carries tlast.
// Reset (rst_n, async, low): counter 0, all slots free, RF events off, no beat pending.
module millisecond_tick_timer_slots_core #(
    parameter int SLOT_COUNT = mtts_pkg::SLOT_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mtts_pkg::S_TDATA_W-1:0]   s_tdata,    // timer_id[7:0], delay_ms[39:8]
    input  logic [mtts_pkg::CMD_W-1:0]       s_tuser,    // cmd[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mtts_pkg::M_TDATA_W-1:0]   m_tdata,    // fired_id[7:0], led_on[8], time_ms[40:9]
    output logic [mtts_pkg::EV_W-1:0]        m_tuser,    // event_res[2:0]
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mtts_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [mtts_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mtts_pkg::*;

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_SET,
        ST_FLUSH
    } state_t;

    state_t                  state_reg;
    cmd_t                    cmd_reg;
    logic [ID_W-1:0]         id_reg;
    logic [TIME_W-1:0]       delay_reg;
    logic [TIME_W-1:0]       elapsed_reg;
    logic [LED_MOD_W-1:0]    mod10_reg;
    logic                    rf_enable_reg;
    logic [CFG_DATA_W-1:0]   rf_period_reg;
    logic [ID_W-1:0]         owner_reg [SLOT_COUNT];
    logic [TIME_W-1:0]       deadline_reg [SLOT_COUNT];
    logic [SLOT_IDX_W-1:0]   idx_reg;
    logic                    found_reg;
    logic [SLOT_IDX_W-1:0]   found_idx_reg;
    logic                    free_ok_reg;
    logic [SLOT_IDX_W-1:0]   free_idx_reg;
    logic                    pend_valid_reg;
    ev_t                     pend_ev_reg;
    logic [ID_W-1:0]         pend_id_reg;
    logic                    m_tvalid_reg;
    ev_t                     out_ev_reg;
    logic [ID_W-1:0]         out_id_reg;
    logic                    out_led_reg;
    logic [TIME_W-1:0]       out_time_reg;
    logic                    out_last_reg;

    logic                    accept;
    cmd_t                    in_cmd;
    logic [ID_W-1:0]         in_id;
    logic [TIME_W-1:0]       in_delay;
    logic [TIME_W-1:0]       elapsed_inc;
    logic [LED_MOD_W-1:0]    mod10_inc;
    logic                    rf_active;
    logic                    out_free;
    logic                    led_now;
    logic                    hit;
    logic                    own_match;
    logic                    own_free;
    logic                    scan_last;
    logic                    scan_stall;
    logic                    div_start;
    div_stat_t               div_stat;
    logic                    set_we;
    logic [SLOT_IDX_W-1:0]   set_idx;
    logic [TIME_W-1:0]       delay_eff;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign in_cmd    = cmd_t'(s_tuser);
    assign in_id     = s_tdata[ID_W-1:0];
    assign in_delay  = s_tdata[ID_W +: TIME_W];

    assign elapsed_inc = elapsed_reg + TIME_W'(1);
    // counter wraps to zero, where the decade count restarts too
    assign mod10_inc   = ((elapsed_inc == '0) || (mod10_reg == LED_MOD_W'(LED_MOD - 1)))
                         ? '0 : mod10_reg + LED_MOD_W'(1);
    assign led_now     = (mod10_reg < LED_MOD_W'(LED_OFF_FROM));

    assign rf_active = rf_enable_reg && (rf_period_reg != '0);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign hit        = (owner_reg[idx_reg] != '0) && (deadline_reg[idx_reg] == elapsed_reg);
    assign own_match  = (owner_reg[idx_reg] == id_reg);
    assign own_free   = (owner_reg[idx_reg] == '0);
    assign scan_last  = (idx_reg == SLOT_IDX_W'(SLOT_COUNT - 1));
    // a second firing has to push the held one out first
    assign scan_stall = (state_reg == ST_SCAN) && (cmd_reg == CMD_TICK) && hit
                        && pend_valid_reg && !out_free;

    assign div_start = accept && (in_cmd == CMD_TICK) && rf_active;

    assign set_we    = (state_reg == ST_SET) && (found_reg || free_ok_reg);
    assign set_idx   = found_reg ? found_idx_reg : free_idx_reg;
    assign delay_eff = (delay_reg == '0) ? TIME_W'(1) : delay_reg;

    mtts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed_inc),
        .divisor  (rf_period_reg),
        .stat     (div_stat)
    );

    always_ff @(posedge clk)
    begin
        if (set_we)
        begin
            deadline_reg[set_idx] <= elapsed_reg + delay_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= CMD_TICK;
            id_reg         <= '0;
            delay_reg      <= '0;
            elapsed_reg    <= '0;
            mod10_reg      <= '0;
            rf_enable_reg  <= 1'b0;
            rf_period_reg  <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                owner_reg[i] <= '0;
            end
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            found_idx_reg  <= '0;
            free_ok_reg    <= 1'b0;
            free_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_ev_reg    <= EV_QUIET;
            pend_id_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            out_ev_reg     <= EV_QUIET;
            out_id_reg     <= '0;
            out_led_reg    <= 1'b0;
            out_time_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_RF_ENABLE: rf_enable_reg <= cfg_data[0];
                    REG_RF_PERIOD: rf_period_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg        <= in_cmd;
                        id_reg         <= in_id;
                        delay_reg      <= in_delay;
                        pend_valid_reg <= 1'b0;
                        idx_reg        <= '0;
                        found_reg      <= 1'b0;
                        free_ok_reg    <= 1'b0;
                        case (in_cmd)
                            CMD_TICK:
                            begin
                                elapsed_reg <= elapsed_inc;
                                mod10_reg   <= mod10_inc;
                                state_reg   <= rf_active ? ST_DIV : ST_SCAN;
                            end
                            CMD_SET, CMD_CLEAR:
                            begin
                                if (in_id == '0)
                                begin
                                    pend_valid_reg <= 1'b1;
                                    pend_ev_reg    <= EV_DONE;
                                    pend_id_reg    <= '0;
                                    state_reg      <= ST_FLUSH;
                                end
                                else
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_FLUSH;
                            end
                        endcase
                    end
                end

                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        if (div_stat.rem == '0)
                        begin
                            pend_valid_reg <= 1'b1;
                            pend_ev_reg    <= EV_MIX;
                            pend_id_reg    <= '0;
                        end
                        else if (div_stat.rem == DIVISOR_W'(1))
                        begin
                            pend_valid_reg <= 1'b1;
                            pend_ev_reg    <= EV_RF;
                            pend_id_reg    <= '0;
                        end
                        state_reg <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    if (!scan_stall)
                    begin
                        case (cmd_reg)
                            CMD_TICK:
                            begin
                                if (hit)
                                begin
                                    if (pend_valid_reg)
                                    begin
                                        m_tvalid_reg <= 1'b1;
                                        out_ev_reg   <= pend_ev_reg;
                                        out_id_reg   <= pend_id_reg;
                                        out_led_reg  <= led_now;
                                        out_time_reg <= elapsed_reg;
                                        out_last_reg <= 1'b0;
                                    end
                                    owner_reg[idx_reg] <= '0;
                                    pend_valid_reg     <= 1'b1;
                                    pend_ev_reg        <= EV_FIRED;
                                    pend_id_reg        <= owner_reg[idx_reg];
                                end
                            end
                            CMD_SET:
                            begin
                                if (own_match && !found_reg)
                                begin
                                    found_reg     <= 1'b1;
                                    found_idx_reg <= idx_reg;
                                end
                                if (own_free && !free_ok_reg)
                                begin
                                    free_ok_reg  <= 1'b1;
                                    free_idx_reg <= idx_reg;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                if (own_match)
                                begin
                                    owner_reg[idx_reg] <= '0;
                                end
                                if (scan_last)
                                begin
                                    pend_valid_reg <= 1'b1;
                                    pend_ev_reg    <= EV_DONE;
                                    pend_id_reg    <= '0;
                                end
                            end
                            default: ;
                        endcase

                        if (scan_last)
                        begin
                            state_reg <= (cmd_reg == CMD_SET) ? ST_SET : ST_FLUSH;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + SLOT_IDX_W'(1);
                        end
                    end
                end

                ST_SET:
                begin
                    pend_valid_reg <= 1'b1;
                    pend_id_reg    <= '0;
                    if (found_reg || free_ok_reg)
                    begin
                        owner_reg[set_idx] <= id_reg;
                        pend_ev_reg        <= EV_DONE;
                    end
                    else
                    begin
                        pend_ev_reg <= EV_FULL;
                    end
                    state_reg <= ST_FLUSH;
                end

                ST_FLUSH:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        out_ev_reg   <= pend_valid_reg ? pend_ev_reg : EV_QUIET;
                        out_id_reg   <= pend_valid_reg ? pend_id_reg : '0;
                        out_led_reg  <= led_now;
                        out_time_reg <= elapsed_reg;
                        out_last_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - ID_W - 1 - TIME_W){1'b0}},
                       out_time_reg, out_led_reg, out_id_reg};

endmodule

@@ hw/rtl/mtts_div.sv @@
module mtts_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [mtts_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [mtts_pkg::DIVISOR_W-1:0]    divisor,
    output mtts_pkg::div_stat_t               stat
);
    import mtts_pkg::*;

    localparam int STEPS = DIVIDEND_W / DIV_STEP_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] num_reg;
    logic [DIVISOR_W-1:0]  dsor_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W:0]    trial;

    // restoring remainder, DIV_STEP_BITS dividend bits per cycle, MSB first
    always_comb
    begin
        rem_next = rem_reg;
        trial    = '0;
        for (int k = 0; k < DIV_STEP_BITS; k++)
        begin
            trial = {rem_next, num_reg[DIVIDEND_W-1-k]};
            if (trial >= {1'b0, dsor_reg})
            begin
                trial = trial - {1'b0, dsor_reg};
            end
            rem_next = trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            dsor_reg <= '0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(STEPS);
            num_reg  <= dividend;
            dsor_reg <= divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= num_reg << DIV_STEP_BITS;
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

@@ hw/rtl/mtts_checker.sv @@
`include "millisecond_tick_timer_slots_core_assert.svh"

module mtts_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mtts_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [mtts_pkg::EV_W-1:0]        m_tuser,
    input logic                             m_tlast
);
    import mtts_pkg::*;

    // a stalled beat keeps its contents
    `MTTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // an item is worked on alone: no new beat taken in the cycle after one is
    `MTTS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

    // while more beats of an item are due, no new item comes in
    `MTTS_ASSERT_NOW(a_busy_mid_item, m_tvalid && !m_tlast, !s_tready)

    // only an expiry beat names a timer
    `MTTS_ASSERT_NOW(a_id_on_fire, m_tvalid && (m_tuser != EV_FIRED), m_tdata[ID_W-1:0] == '0)

    // expiry never carries id zero
    `MTTS_ASSERT_NOW(a_fire_id, m_tvalid && (m_tuser == EV_FIRED), m_tdata[ID_W-1:0] != '0)

endmodule

bind millisecond_tick_timer_slots_core mtts_checker u_mtts_checker (.*);

@@ dv/millisecond_tick_timer_slots_core_test.sv @@
`timescale 1ns / 100ps

module millisecond_tick_timer_slots_core_test;
    import mtts_pkg::*;

    localparam int          SLOT_N        = SLOT_COUNT_DEF;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam int          LED_PERIOD_MS = 10;
    localparam int          LED_DARK_FROM = 8;
    localparam int          MAX_GAP       = 6;
    localparam int          SETTLE_CYCLES = 30;
    localparam int          HOLD_CYCLES   = 200;
    localparam int          CYCLE_LIMIT   = 300000;

    typedef struct {
        ev_t         ev;
        logic [7:0]  fired_id;
        logic        led_on;
        logic [31:0] time_ms;
        logic        last;
    } wheel_event_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic [CMD_W-1:0]        s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [EV_W-1:0]         m_tuser;
    logic                    m_tlast;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [REG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // shadow of the timer wheel
    logic [31:0]  clock_ms;
    logic [7:0]   owner_id [SLOT_N];
    logic [31:0]  due_ms   [SLOT_N];
    logic         rf_on;
    logic [15:0]  rf_period;

    wheel_event_t pending_events[$];

    int  errors;
    int  items_sent;
    int  beats_checked;
    int  expiries_seen;
    int  cycle_count;
    int  rx_gap;
    bit  rx_hold;
    bit  tx_idle;
    bit  rx_idle;

    millisecond_tick_timer_slots_core #(
        .SLOT_COUNT (SLOT_N)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch at beat %0d: %s got 0x%0h want 0x%0h",
                 beats_checked, what, got, want);
    endtask

    function automatic int find_owner(input logic [7:0] id);
        for (int i = 0; i < SLOT_N; i++)
        begin
            if (owner_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic wheel_event_t make_event(input ev_t ev, input logic [7:0] who);
        wheel_event_t e;
        e.ev       = ev;
        e.fired_id = who;
        e.led_on   = ((clock_ms % LED_PERIOD_MS) >= LED_DARK_FROM) ? 1'b0 : 1'b1;
        e.time_ms  = clock_ms;
        e.last     = 1'b0;
        return e;
    endfunction

    // advance the shadow wheel by one request and queue the beats it causes
    function automatic void wheel_step(input logic [1:0] cmd, input logic [7:0] id,
                                       input logic [31:0] dly);
        wheel_event_t outs[$];
        logic [31:0]  rem;
        int           s;

        if (cmd == CMD_TICK)
        begin
            clock_ms = clock_ms + 32'd1;
            if (rf_on && rf_period != 16'd0)
            begin
                rem = clock_ms % rf_period;
                if (rem == 32'd0)
                    outs.push_back(make_event(EV_MIX, 8'd0));
                else if (rem == 32'd1)
                    outs.push_back(make_event(EV_RF, 8'd0));
            end
            for (int i = 0; i < SLOT_N; i++)
            begin
                if (owner_id[i] != 8'd0 && due_ms[i] == clock_ms)
                begin
                    outs.push_back(make_event(EV_FIRED, owner_id[i]));
                    owner_id[i] = 8'd0;
                end
            end
            if (outs.size() == 0)
                outs.push_back(make_event(EV_QUIET, 8'd0));
        end
        else if (cmd == CMD_SET)
        begin
            if (id == 8'd0)
                outs.push_back(make_event(EV_DONE, 8'd0));
            else
            begin
                s = find_owner(id);
                if (s < 0)
                    s = find_owner(8'd0);
                if (s < 0)
                    outs.push_back(make_event(EV_FULL, 8'd0));
                else
                begin
                    owner_id[s] = id;
                    due_ms[s]   = clock_ms + ((dly == 32'd0) ? 32'd1 : dly);
                    outs.push_back(make_event(EV_DONE, 8'd0));
                end
            end
        end
        else if (cmd == CMD_CLEAR)
        begin
            if (id != 8'd0)
            begin
                s = find_owner(id);
                if (s >= 0)
                    owner_id[s] = 8'd0;
            end
            outs.push_back(make_event(EV_DONE, 8'd0));
        end
        else
            outs.push_back(make_event(EV_QUIET, 8'd0));

        outs[outs.size() - 1].last = 1'b1;
        foreach (outs[k])
            pending_events.push_back(outs[k]);
    endfunction

    // entered and left on a falling edge; tvalid stays up for a back-to-back beat
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] id,
                             input logic [31:0] dly);
        int gap;

        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {dly, id};
        do
            @(posedge clk);
        while (!s_tready);
        wheel_step(cmd, id, dly);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_item();
        int          pick;
        logic [1:0]  cmd;
        logic [7:0]  id;
        logic [31:0] dly;

        pick = $urandom_range(0, 99);
        // a small id pool keeps the slots busy and full; now and then any id
        id  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
        dly = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 8));
        if (pick < 50)
            cmd = CMD_TICK;
        else if (pick < 78)
            cmd = CMD_SET;
        else if (pick < 95)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_UNUSED;
        send_item(cmd, id, dly);
    endtask

    task automatic wait_until_quiet();
        s_tvalid = 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_RF_ENABLE)
            rf_on = data[0];
        else
            rf_period = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_rf(input logic en, input logic [15:0] period);
        wait_until_quiet();
        write_reg(REG_RF_ENABLE, {15'd0, en});
        write_reg(REG_RF_PERIOD, period);
    endtask

    task automatic test_requests_and_expiry();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_item(CMD_TICK, 8'd0, 32'd0);
        send_item(CMD_SET, 8'd0, 32'd5);             // id zero does nothing
        send_item(CMD_CLEAR, 8'd0, 32'd0);
        send_item(CMD_CLEAR, 8'h55, 32'd0);          // unknown id
        send_item(CMD_UNUSED, 8'h12, 32'h0000_0003); // counter must not move
        send_item(CMD_SET, 8'hFF, 32'd0);            // zero delay counts as one
        send_item(CMD_TICK, 8'd0, 32'd0);
        send_item(CMD_SET, 8'd1, 32'd3);
        send_item(CMD_SET, 8'd2, 32'd3);
        send_item(CMD_SET, 8'd3, 32'hFFFF_FFFF);     // deadline wraps behind us
        send_item(CMD_SET, 8'd4, 32'd5);             // all slots taken
        send_item(CMD_SET, 8'd2, 32'd3);             // re-arm works when full
        send_item(CMD_CLEAR, 8'd3, 32'd0);
        send_item(CMD_SET, 8'h80, 32'd3);
        // period of one: every tick prepares the mixer; the third tick also
        // fires all three slots at once
        set_rf(1'b1, 16'd1);
        repeat (7) send_item(CMD_TICK, 8'd0, 32'd0);
    endtask

    task automatic test_rf_periods();
        logic        en  [6];
        logic [15:0] per [6];

        en[0] = 1'b1; per[0] = 16'd2;
        en[1] = 1'b1; per[1] = 16'd5;
        en[2] = 1'b0; per[2] = 16'd3;
        en[3] = 1'b1; per[3] = 16'd0;
        en[4] = 1'b1; per[4] = 16'hFFFF;
        en[5] = 1'b1; per[5] = 16'($urandom_range(3, 12));
        for (int p = 0; p < 6; p++)
        begin
            set_rf(en[p], per[p]);
            // one phase runs flat out on both sides
            tx_idle = (p != 1);
            rx_idle = (p != 1);
            repeat (12) send_random_item();
        end
    endtask

    task automatic test_output_backpressure();
        set_rf(1'b1, 16'd3);
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        fork
            begin
                @(posedge clk);
                rx_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            repeat (25) send_random_item();
        join
    endtask

    // result side: ready pattern on the falling edge
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold)
                m_tready = 1'b0;
            else if (rx_gap > 0)
            begin
                m_tready = 1'b0;
                rx_gap--;
            end
            else
                m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_events.size() == 0)
            begin
                errors++;
                $display("unexpected beat: event %0d time %0d", m_tuser, m_tdata[40:9]);
            end
            else
            begin
                wheel_event_t want;
                want = pending_events.pop_front();
                if (m_tuser !== want.ev)
                    report_mismatch("event_res", 32'(m_tuser), 32'(want.ev));
                if (m_tdata[7:0] !== want.fired_id)
                    report_mismatch("fired_id", 32'(m_tdata[7:0]), 32'(want.fired_id));
                if (m_tdata[8] !== want.led_on)
                    report_mismatch("led_on", 32'(m_tdata[8]), 32'(want.led_on));
                if (m_tdata[40:9] !== want.time_ms)
                    report_mismatch("time_ms", m_tdata[40:9], want.time_ms);
                if (m_tlast !== want.last)
                    report_mismatch("tlast", 32'(m_tlast), 32'(want.last));
                if (want.ev == EV_FIRED)
                    expiries_seen++;
            end
            beats_checked++;
            rx_gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timed out with %0d beats outstanding", pending_events.size());
            $display("millisecond_tick_timer_slots_core_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rx_hold   = 1'b0;
        rx_gap    = 0;
        tx_idle   = 1'b1;
        rx_idle   = 1'b1;
        errors        = 0;
        items_sent    = 0;
        beats_checked = 0;
        expiries_seen = 0;
        cycle_count   = 0;
        clock_ms  = 32'd0;
        rf_on     = 1'b0;
        rf_period = 16'd0;
        for (int i = 0; i < SLOT_N; i++)
        begin
            owner_id[i] = 8'd0;
            due_ms[i]   = 32'd0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_requests_and_expiry();
        test_rf_periods();
        test_output_backpressure();

        wait_until_quiet();
        if (pending_events.size() != 0)
        begin
            errors++;
            $display("%0d expected beats never arrived", pending_events.size());
        end
        $display("covered %0d requests and %0d result beats, %0d of them timer expiries,",
                 items_sent, beats_checked, expiries_seen);
        $display("over several RF settings and one long output stall; %0d mismatches", errors);
        if (errors == 0)
            $display("millisecond_tick_timer_slots_core_test OK");
        else
            $display("millisecond_tick_timer_slots_core_test NOT OK");
        $finish;
    end

endmodule
